/* hdl/ping_pong_sample_player_top_defines.svh */
// Assertion macros for the sample player control unit.
`ifndef PING_PONG_SAMPLE_PLAYER_TOP_DEFINES_SVH
`define PING_PONG_SAMPLE_PLAYER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pps_pkg.sv */
// Shared types, constants and address helper for the sample player.
`timescale 1ns / 1ps

package pps_pkg;

    // Bytes in one bank of the sample store.
    localparam int BANK_BYTES = 512;
    localparam int IDX_W      = (BANK_BYTES > 1) ? $clog2(BANK_BYTES) : 1;
    localparam int FILL_W     = $clog2(BANK_BYTES + 1);
    localparam int ADDR_W     = $clog2(2 * BANK_BYTES);
    localparam int STORE_DEPTH = 2 * BANK_BYTES;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(BANK_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BANK_BYTES);

    // Request function codes.
    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_LOAD_START = 2'd1,
        FUNC_LOAD_BYTE  = 2'd2,
        FUNC_LOAD_END   = 2'd3
    } func_t;

    // Per-request result flags handed from the control unit to the output stage.
    typedef struct packed {
        logic tick_read;
        logic swapped;
        logic held;
        logic end_of_file;
    } result_flags_t;

    // Store address of one byte within a bank.
    function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
                                                     input logic [IDX_W-1:0] idx);
        store_addr = bank ? (ADDR_W'(BANK_BYTES) + ADDR_W'(idx)) : ADDR_W'(idx);
    endfunction

endpackage

/* hdl/pps_store.sv */
// Two-bank sample memory with one write port and one registered read port.
`timescale 1ns / 1ps

module pps_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [pps_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [pps_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [pps_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port: loader bytes into the idle bank.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: the playing bank's current byte, held until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/pps_ctrl.sv */
// Playback and load control: bank, play position, fill count and flags.
`timescale 1ns / 1ps
`include "ping_pong_sample_player_top_defines.svh"

module pps_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  logic [1:0]                    func,
    output logic                          wr_en,
    output logic [pps_pkg::ADDR_W-1:0]    wr_addr,
    output logic [pps_pkg::ADDR_W-1:0]    rd_addr,
    output pps_pkg::result_flags_t        flags
);

    pps_pkg::func_t              func_sel;
    logic                        play_bank_reg,  play_bank_next;
    logic [pps_pkg::IDX_W-1:0]   play_index_reg, play_index_next;
    logic [pps_pkg::FILL_W-1:0]  fill_count_reg, fill_count_next;
    logic                        loading_reg,    loading_next;
    logic                        started_reg,    started_next;
    logic                        eof_seen_reg,   eof_seen_next;
    logic                        swapped;
    logic                        held;
    logic                        tick_read;
    logic                        fill_room;

    assign func_sel  = pps_pkg::func_t'(func);
    assign fill_room = (fill_count_reg < pps_pkg::FILL_MAX);

    // Next state and result flags for the request being accepted.
    always_comb begin
        play_bank_next  = play_bank_reg;
        play_index_next = play_index_reg;
        fill_count_next = fill_count_reg;
        loading_next    = loading_reg;
        started_next    = started_reg;
        eof_seen_next   = eof_seen_reg;
        swapped         = 1'b0;
        held            = 1'b0;
        tick_read       = 1'b0;
        wr_en           = 1'b0;
        unique case (func_sel)
            pps_pkg::FUNC_TICK: begin
                if (started_reg) begin
                    tick_read = 1'b1;
                    if (play_index_reg == pps_pkg::LAST_IDX) begin
                        if (loading_reg) begin
                            held = 1'b1;
                        end else begin
                            play_index_next = '0;
                            play_bank_next  = ~play_bank_reg;
                            swapped         = 1'b1;
                        end
                    end else begin
                        play_index_next = play_index_reg + 1'b1;
                    end
                end
            end
            pps_pkg::FUNC_LOAD_START: begin
                loading_next    = 1'b1;
                fill_count_next = '0;
            end
            pps_pkg::FUNC_LOAD_BYTE: begin
                if (loading_reg && fill_room) begin
                    wr_en           = in_accept;
                    fill_count_next = fill_count_reg + 1'b1;
                end
            end
            pps_pkg::FUNC_LOAD_END: begin
                if (loading_reg) begin
                    loading_next = 1'b0;
                    if (fill_room) begin
                        eof_seen_next = 1'b1;
                    end
                    if (!started_reg) begin
                        started_next    = 1'b1;
                        play_bank_next  = ~play_bank_reg;
                        play_index_next = '0;
                        swapped         = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Memory addresses: loads go to the idle bank, ticks read the playing bank.
    assign wr_addr = pps_pkg::store_addr(~play_bank_reg,
                                         fill_count_reg[pps_pkg::IDX_W-1:0]);
    assign rd_addr = pps_pkg::store_addr(play_bank_reg, play_index_reg);

    assign flags.tick_read   = tick_read;
    assign flags.swapped     = swapped;
    assign flags.held        = held;
    assign flags.end_of_file = eof_seen_next;

    // Control state, updated once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_bank_reg  <= 1'b1;
            play_index_reg <= '0;
            fill_count_reg <= '0;
            loading_reg    <= 1'b0;
            started_reg    <= 1'b0;
            eof_seen_reg   <= 1'b0;
        end else if (in_accept) begin
            play_bank_reg  <= play_bank_next;
            play_index_reg <= play_index_next;
            fill_count_reg <= fill_count_next;
            loading_reg    <= loading_next;
            started_reg    <= started_next;
            eof_seen_reg   <= eof_seen_next;
        end
    end

    `PPS_ASSERT_IMPLY(a_fill_bound, aclk, aresetn, 1'b1, fill_count_reg <= pps_pkg::FILL_MAX, "fill count beyond bank size")
    `PPS_ASSERT_IMPLY(a_idle_index, aclk, aresetn, !started_reg, play_index_reg == '0, "play index moved before playback started")
    `PPS_ASSERT_IMPLY(a_held_busy, aclk, aresetn, in_accept && held, loading_reg && !swapped, "hold without a busy load")
    `PPS_ASSERT_NEXT(a_eof_sticky, aclk, aresetn, eof_seen_reg, eof_seen_reg, "end of file flag cleared")

endmodule

/* hdl/pps_out.sv */
// Result stage: holds one finished request and keeps the last output level.
`timescale 1ns / 1ps

module pps_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_accept,
    input  pps_pkg::result_flags_t flags,
    input  logic [7:0]             rd_data,
    output logic                   in_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_level,
    output logic                   m_swapped,
    output logic                   m_held,
    output logic                   m_end_of_file
);

    logic                   res_valid_reg;
    pps_pkg::result_flags_t res_flags_reg;
    logic [7:0]             last_level_reg;

    // A new request may enter when no result is held or the held result leaves in the same cycle.
    assign in_ready = !res_valid_reg || m_ready;

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (in_accept) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result flags payload.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            res_flags_reg <= flags;
        end
    end

    // The level of a delivered tick becomes the level for later requests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= '0;
        end else if (res_valid_reg && m_ready && res_flags_reg.tick_read) begin
            last_level_reg <= rd_data;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_level       = res_flags_reg.tick_read ? rd_data : last_level_reg;
    assign m_swapped     = res_flags_reg.swapped;
    assign m_held        = res_flags_reg.held;
    assign m_end_of_file = res_flags_reg.end_of_file;

endmodule

/* hdl/ping_pong_sample_player_top.sv */
// Timing: a result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver takes each result; the single
// registered read port of the sample store and the one-entry result stage set this figure.
// Reset: aresetn is synchronous and active low; it clears all control state,
// selects bank one for playback and sets the level to zero. Store contents are kept.
`timescale 1ns / 1ps

module ping_pong_sample_player_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_sample,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_level,
    output logic       m_swapped,
    output logic       m_held,
    output logic       m_end_of_file
);

    logic                       in_accept;
    logic                       wr_en;
    logic [pps_pkg::ADDR_W-1:0] wr_addr;
    logic [pps_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;
    pps_pkg::result_flags_t     flags;

    assign in_accept = s_valid && s_ready;

    // Bank, position and load control.
    pps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .func      (s_func),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .flags     (flags)
    );

    // Sample memory; every accepted request refreshes the read register.
    pps_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_sample),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register and last level.
    pps_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .flags         (flags),
        .rd_data       (rd_data),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_swapped     (m_swapped),
        .m_held        (m_held),
        .m_end_of_file (m_end_of_file)
    );

endmodule

/* dv/ping_pong_sample_player_top_test.sv */
// Self-checking testbench for the double-buffered sample player.
`timescale 1ns / 1ps

module ping_pong_sample_player_top_test;

    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    // One result of the player, field for field.
    typedef struct packed {
        logic [7:0] level;
        logic       swapped;
        logic       held;
        logic       end_of_file;
    } player_result_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_valid  = 1'b0;
    logic       s_ready;
    logic [1:0] s_func   = pps_pkg::FUNC_TICK;
    logic [7:0] s_sample = 8'h00;
    logic       m_valid;
    logic       m_ready  = 1'b0;
    logic [7:0] m_level;
    logic       m_swapped;
    logic       m_held;
    logic       m_end_of_file;

    ping_pong_sample_player_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_swapped     (m_swapped),
        .m_held        (m_held),
        .m_end_of_file (m_end_of_file)
    );

    // Shadow copy of the player state.
    logic [7:0]                 shadow_store [pps_pkg::STORE_DEPTH];
    bit                         shadow_written [pps_pkg::STORE_DEPTH];
    int                         bank_fill_total [2];
    logic                       cur_bank;
    logic [pps_pkg::IDX_W-1:0]  cur_idx;
    logic [pps_pkg::FILL_W-1:0] load_fill;
    bit                         is_loading;
    bit                         is_playing;
    bit                         eof_flag;
    logic [7:0]                 cur_level;
    bit                         request_ignored;

    // Results still owed by the block, oldest first.
    player_result_t pending_results [$];

    // Stimulus control and run statistics.
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int load_length     = 0;
    int load_bytes_sent = 0;
    int stall_cycles    = 0;
    int errors          = 0;
    int requests_sent   = 0;
    int swaps_seen      = 0;
    int holds_seen      = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Position of one byte of a bank in the sample store.
    function automatic int sample_addr(input logic bank, input int idx);
        return (bank ? pps_pkg::BANK_BYTES : 0) + idx;
    endfunction

    // A tick must never read a byte that was never written: the playing bank is
    // always full, so only a swap into a partly loaded idle bank is dangerous.
    function automatic bit tick_safe();
        return !is_playing || is_loading || int'(cur_idx) != pps_pkg::BANK_BYTES - 1
            || bank_fill_total[cur_bank ^ 1'b1] == pps_pkg::BANK_BYTES;
    endfunction

    task automatic reset_shadow();
        foreach (shadow_written[i]) shadow_written[i] = 1'b0;
        bank_fill_total[0] = 0;
        bank_fill_total[1] = 0;
        cur_bank   = 1'b1;
        cur_idx    = '0;
        load_fill  = '0;
        is_loading = 1'b0;
        is_playing = 1'b0;
        eof_flag   = 1'b0;
        cur_level  = 8'h00;
    endtask

    // Advances the shadow state by one request and returns the result it causes.
    task automatic predict_player_result(input pps_pkg::func_t f, input logic [7:0] smp,
                                         output player_result_t r);
        int a;
        r.swapped = 1'b0;
        r.held    = 1'b0;
        request_ignored = 1'b0;
        case (f)
            pps_pkg::FUNC_TICK: begin
                if (is_playing) begin
                    cur_level = shadow_store[sample_addr(cur_bank, int'(cur_idx))];
                    if (int'(cur_idx) == pps_pkg::BANK_BYTES - 1) begin
                        if (is_loading) begin
                            r.held = 1'b1;
                        end else begin
                            cur_idx   = '0;
                            cur_bank  = ~cur_bank;
                            r.swapped = 1'b1;
                        end
                    end else begin
                        cur_idx = cur_idx + 1'b1;
                    end
                end else begin
                    request_ignored = 1'b1;
                end
            end
            pps_pkg::FUNC_LOAD_START: begin
                is_loading = 1'b1;
                load_fill  = '0;
            end
            pps_pkg::FUNC_LOAD_BYTE: begin
                if (is_loading && int'(load_fill) < pps_pkg::BANK_BYTES) begin
                    a = sample_addr(cur_bank ^ 1'b1, int'(load_fill));
                    shadow_store[a] = smp;
                    if (!shadow_written[a]) begin
                        shadow_written[a] = 1'b1;
                        bank_fill_total[cur_bank ^ 1'b1]++;
                    end
                    load_fill = load_fill + 1'b1;
                end else begin
                    request_ignored = 1'b1;
                end
            end
            default: begin
                if (is_loading) begin
                    is_loading = 1'b0;
                    if (int'(load_fill) < pps_pkg::BANK_BYTES) eof_flag = 1'b1;
                    if (!is_playing) begin
                        is_playing = 1'b1;
                        cur_bank   = ~cur_bank;
                        cur_idx    = '0;
                        r.swapped  = 1'b1;
                    end
                end else begin
                    request_ignored = 1'b1;
                end
            end
        endcase
        r.level       = cur_level;
        r.end_of_file = eof_flag;
        if (r.swapped) swaps_seen++;
        if (r.held) holds_seen++;
    endtask

    // Offers one request, waits for it to be taken and records what it should cause.
    task automatic send_request(input pps_pkg::func_t f, input logic [7:0] smp);
        player_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= f;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_player_result(f, smp, r);
        pending_results.push_back(r);
        requests_sent++;
    endtask

    // Mostly well-formed loads interleaved with playback ticks, plus some noise.
    task automatic send_random_request();
        pps_pkg::func_t f;
        logic [7:0]     smp;
        int             roll;
        smp  = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (is_playing && swaps_seen >= 2 && roll < 6) begin
            f = pps_pkg::func_t'($urandom_range(0, 3));
        end else if (!is_loading) begin
            f = (roll < 96) ? pps_pkg::FUNC_TICK : pps_pkg::FUNC_LOAD_START;
        end else if (load_bytes_sent < load_length) begin
            f = (roll < 50) ? pps_pkg::FUNC_TICK : pps_pkg::FUNC_LOAD_BYTE;
        end else begin
            f = (roll < 40) ? pps_pkg::FUNC_TICK : pps_pkg::FUNC_LOAD_END;
        end
        // Keep playback on bytes that hold real data.
        if (f == pps_pkg::FUNC_TICK && !tick_safe()) begin
            f = is_loading ? pps_pkg::FUNC_LOAD_BYTE : pps_pkg::FUNC_LOAD_START;
        end
        if (f == pps_pkg::FUNC_LOAD_END && !is_playing
                && bank_fill_total[cur_bank ^ 1'b1] != pps_pkg::BANK_BYTES) begin
            f = pps_pkg::FUNC_LOAD_BYTE;
        end
        // Short loads only once playback has gone round.
        if (f == pps_pkg::FUNC_LOAD_START) begin
            load_bytes_sent = 0;
            roll = $urandom_range(0, 99);
            if (swaps_seen >= 2 && roll < 15) begin
                load_length = $urandom_range(0, pps_pkg::BANK_BYTES - 1);
            end else if (roll < 35) begin
                load_length = pps_pkg::BANK_BYTES + $urandom_range(1, 4);
            end else begin
                load_length = pps_pkg::BANK_BYTES;
            end
        end else if (f == pps_pkg::FUNC_LOAD_BYTE && is_loading) begin
            load_bytes_sent++;
        end
        send_request(f, smp);
    endtask

    // Ticks, stray bytes and stray load ends before playback has begun, then a load that is restarted.
    task automatic test_before_start();
        send_request(pps_pkg::FUNC_TICK, 8'hFF);
        send_request(pps_pkg::FUNC_TICK, 8'h00);
        send_request(pps_pkg::FUNC_LOAD_BYTE, 8'h5A);
        send_request(pps_pkg::FUNC_LOAD_END, 8'hA5);
        send_request(pps_pkg::FUNC_LOAD_START, 8'h00);
        send_request(pps_pkg::FUNC_LOAD_BYTE, 8'hFF);
        send_request(pps_pkg::FUNC_LOAD_BYTE, 8'h00);
        send_request(pps_pkg::FUNC_TICK, 8'h3C);
        send_request(pps_pkg::FUNC_LOAD_START, 8'hFF);
    endtask

    // Fills bank zero past its end, starts playback and plays the edge values.
    task automatic test_first_load();
        logic [7:0] edge_bytes [6];
        edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h04, 8'h80, 8'h7F};
        for (int i = 0; i < pps_pkg::BANK_BYTES + 3; i++) begin
            send_request(pps_pkg::FUNC_LOAD_BYTE, (i < 6) ? edge_bytes[i] : 8'($urandom));
        end
        send_request(pps_pkg::FUNC_LOAD_END, 8'h00);
        for (int i = 0; i < 8; i++) send_request(pps_pkg::FUNC_TICK, 8'($urandom));
    endtask

    // A load that ends short of a full bank raises the sticky end of file flag.
    task automatic test_short_load();
        send_request(pps_pkg::FUNC_LOAD_START, 8'h00);
        for (int i = 0; i < 5; i++) send_request(pps_pkg::FUNC_LOAD_BYTE, 8'($urandom));
        send_request(pps_pkg::FUNC_LOAD_END, 8'h00);
    endtask

    // Random traffic until the given number of requests has had an effect.
    task automatic test_random_mix(input int count);
        int done;
        done = 0;
        while (done < count) begin
            send_random_request();
            if (!request_ignored) done++;
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        for (int i = 0; i < 40; i++) send_random_request();
    endtask

    // Result ready: random stalls, and long holds when the test asks for one.
    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compares every accepted result with the oldest one owed.
    always @(posedge aclk) begin
        player_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: level %0d swapped %0d held %0d end_of_file %0d",
                       m_level, m_swapped, m_held, m_end_of_file);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_level !== want.level) begin
                    $error("level: expected %0d, actual %0d", want.level, m_level);
                    errors++;
                end
                if (m_swapped !== want.swapped) begin
                    $error("swapped: expected %0d, actual %0d", want.swapped, m_swapped);
                    errors++;
                end
                if (m_held !== want.held) begin
                    $error("held: expected %0d, actual %0d", want.held, m_held);
                    errors++;
                end
                if (m_end_of_file !== want.end_of_file) begin
                    $error("end_of_file: expected %0d, actual %0d",
                           want.end_of_file, m_end_of_file);
                    errors++;
                end
            end
        end
    end

    // Ends the run if neither channel moves a request for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_before_start();
        test_first_load();
        test_short_load();
        send_idle_pct = 31;
        recv_idle_pct = 87;
        test_random_mix(70);
        send_idle_pct = 87;
        recv_idle_pct = 31;
        test_random_mix(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(30);
        test_result_backpressure();

        // Let the last results drain before judging the run.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d requests checked, %0d bank swaps, %0d held ticks",
                 requests_sent, swaps_seen, holds_seen);
        $display("tb: loads covered restart, overflow and short end; end of file reached: %0d",
                 eof_flag);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
